// ----- hdl/spq_pkg.sv -----
// Shared types and codes for the sorted-list priority queue.
package spq_pkg;

  // Request operation codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned OCC_W   = 5;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [1:0]         status;
    logic        [OCC_W-1:0]   occupancy;
  } result_t;

endpackage

// ----- hdl/spq_mem.sv -----
// Entry store: one write port and one registered read port.
module spq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  spq_pkg::entry_t  wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output spq_pkg::entry_t  rd_data_o
);

  spq_pkg::entry_t mem_q [DEPTH];
  spq_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    // hold read data unless a new read is issued
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/spq_ctrl.sv -----
// Sequencer: insertion walk, head removal, entry count and head pointer.
module spq_ctrl #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned AW       = 4,
  parameter int unsigned CW       = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic signed [spq_pkg::VALUE_W-1:0]  item_value_i,
  input  logic        [spq_pkg::PRIO_W-1:0]   item_priority_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output spq_pkg::result_t                    res_o,
  output logic                                wr_en_o,
  output logic [AW-1:0]                       wr_addr_o,
  output spq_pkg::entry_t                     wr_data_o,
  output logic                                rd_en_o,
  output logic [AW-1:0]                       rd_addr_o,
  input  spq_pkg::entry_t                     rd_data_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_INS    = 3'd2;
  localparam logic [2:0] S_PLACE  = 3'd3;
  localparam logic [2:0] S_DEQ    = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]                          state_q, state_d;
  logic                                func_q, func_d;
  logic signed [spq_pkg::VALUE_W-1:0]  val_q, val_d;
  logic        [spq_pkg::PRIO_W-1:0]   pri_q, pri_d;
  logic [AW-1:0]                       pos_q, pos_d;
  logic [AW-1:0]                       pos_m1;
  logic [AW-1:0]                       head_q, head_d;
  logic [CW-1:0]                       count_q, count_d;
  logic signed [spq_pkg::VALUE_W-1:0]  res_value_q, res_value_d;
  logic [1:0]                          res_status_q, res_status_d;
  spq_pkg::entry_t                     new_entry;

  // Map a position in the list onto a physical slot of the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] lpos);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, lpos};
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign pos_m1    = pos_q - AW'(1);
  assign new_entry = '{value: val_q, prio: pri_q};

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    val_d        = val_q;
    pri_d        = pri_q;
    pos_d        = pos_q;
    head_d       = head_q;
    count_d      = count_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = '0;
    wr_data_o    = new_entry;
    rd_en_o      = 1'b0;
    rd_addr_o    = '0;
    res_valid_o  = 1'b0;
    in_ready_o   = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_i;
          val_d   = item_value_i;
          pri_d   = item_priority_i;
          state_d = S_START;
        end
      end
      S_START: begin
        res_value_d  = '0;
        res_status_d = spq_pkg::ST_OK;
        if (func_q == spq_pkg::FUNC_DEQ) begin
          if (count_q == '0) begin
            res_status_d = spq_pkg::ST_EMPTY;
            state_d      = S_FINISH;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = head_q;
            state_d   = S_DEQ;
          end
        end else if (count_q == CW'(CAPACITY)) begin
          res_status_d = spq_pkg::ST_FULL;
          state_d      = S_FINISH;
        end else if (count_q == '0) begin
          wr_en_o   = 1'b1;
          wr_addr_o = head_q;
          count_d   = count_q + CW'(1);
          state_d   = S_FINISH;
        end else begin
          // fetch the tail entry and walk towards the head
          rd_en_o   = 1'b1;
          rd_addr_o = phys(head_q, AW'(count_q - CW'(1)));
          pos_d     = AW'(count_q);
          state_d   = S_INS;
        end
      end
      S_INS: begin
        wr_en_o   = 1'b1;
        wr_addr_o = phys(head_q, pos_q);
        if (rd_data_i.prio < pri_q) begin
          // move the lower-priority entry one place back
          wr_data_o = rd_data_i;
          pos_d     = pos_m1;
          if (pos_m1 == '0) begin
            state_d = S_PLACE;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = phys(head_q, pos_m1 - AW'(1));
          end
        end else begin
          count_d = count_q + CW'(1);
          state_d = S_FINISH;
        end
      end
      S_PLACE: begin
        wr_en_o   = 1'b1;
        wr_addr_o = phys(head_q, pos_q);
        count_d   = count_q + CW'(1);
        state_d   = S_FINISH;
      end
      S_DEQ: begin
        res_value_d = rd_data_i.value;
        head_d      = phys(head_q, AW'(1));
        count_d     = count_q - CW'(1);
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = '{value:     res_value_q,
                   status:    res_status_q,
                   occupancy: spq_pkg::OCC_W'(count_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    val_q        <= val_d;
    pri_q        <= pri_d;
    pos_q        <= pos_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
  end

endmodule

// ----- hdl/stable_priority_queue.sv -----
// Top level of the sorted-list priority queue: sequencer, entry store, output register.
//
// Input channel (in_valid_i / in_ready_o) carries one request: func_i selects
// enqueue or dequeue, item_value_i and item_priority_i give the entry.
// Output channel (out_valid_o / out_ready_i) returns one result per request:
// the removed value, a status code and the occupancy after the request.
// Entries sit in a ring memory in priority order, highest first; equal
// priorities leave in arrival order. An enqueue walks back from the tail,
// one entry per cycle through the registered memory read port,
// moving each lower-priority entry one slot back until its place is found.
// One request is in flight at a time; the next is taken once the result
// has entered the output register, so a result may wait there while the
// following request is already being worked on. A stalled receiver holds
// the result; a second finished result then waits in the sequencer and no
// further request is taken.
// Reset empties the queue at once; the memory itself is not cleared.
module stable_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic signed [spq_pkg::VALUE_W-1:0]  item_value_i,
  input  logic        [spq_pkg::PRIO_W-1:0]   item_priority_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [spq_pkg::VALUE_W-1:0]  out_value_o,
  output logic        [1:0]                   status_o,
  output logic        [spq_pkg::OCC_W-1:0]    occupancy_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  spq_pkg::entry_t  wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  spq_pkg::entry_t  rd_data;

  logic             res_valid;
  logic             res_ready;
  spq_pkg::result_t res;

  logic             out_valid_q;
  spq_pkg::result_t out_q;

  spq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data)
  );

  spq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Load the output register whenever it is empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Payload needs no reset; advance only on a fresh result.
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_q.value;
  assign status_o    = out_q.status;
  assign occupancy_o = out_q.occupancy;

`ifndef SYNTHESIS
  // A taken request keeps the input closed for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while the previous one was still at work");

  // A dropped enqueue reports a full queue and no value.
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == spq_pkg::ST_FULL |->
      occupancy_o == spq_pkg::OCC_W'(CAPACITY) && out_value_o == '0)
    else $error("full status with wrong occupancy or value");

  // An empty dequeue reports an empty queue and no value.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == spq_pkg::ST_EMPTY |->
      occupancy_o == '0 && out_value_o == '0)
    else $error("empty status with wrong occupancy or value");

  // A finished result held back by the output register stays offered.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("finished result lost while the output register was full");
`endif

endmodule
